// ===== design/ray_axis_pick_test_defines.svh =====
// Assertion macros used by the pick test design.
`ifndef RAY_AXIS_PICK_TEST_DEFINES_SVH
`define RAY_AXIS_PICK_TEST_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define RAPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define RAPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rapt_pkg.sv =====
// Package with the widths, codes and types of the ray to axis pick test.
package rapt_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int LEN_W      = 31;
    localparam int SQ_W       = 2 * LEN_W;
    localparam int MUL_LIMB_W = 33;
    localparam int MUL_IN_W   = 2 * MUL_LIMB_W;
    localparam int MUL_PP_W   = 2 * MUL_LIMB_W;
    localparam int MUL_X_W    = 2 * MUL_LIMB_W + 1;
    localparam int MUL_MID_W  = 2 * MUL_LIMB_W + 2;
    localparam int MUL_OUT_W  = 2 * MUL_IN_W;
    localparam int QUOT_W     = 32;
    localparam int MAG_W      = SUM_W;
    localparam int DIV_CMP_W  = MAG_W + QUOT_W;
    localparam int DIV_SHIFT  = QUOT_W - FRAC_BITS;

    localparam int FRONT_LAT  = 3;
    localparam int MUL_LAT    = 3;
    localparam int CMP_LAT    = 2;
    localparam int DIV_LAT    = QUOT_W + 1;
    localparam int PIPE_DEPTH = FRONT_LAT + DIV_LAT + 1;
    localparam int STAT_DLY   = DIV_LAT - MUL_LAT - CMP_LAT;

    localparam logic [PROD_W-1:0] PARALLEL_EPS =
        ((64'd1 << (2 * FRAC_BITS)) + 64'd5000) / 64'd10000;

    localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_sel_t;

    typedef enum logic [1:0] {
        STATUS_HIT      = 2'd0,
        STATUS_PARALLEL = 2'd1,
        STATUS_OUTSIDE  = 2'd2,
        STATUS_FAR      = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]   num;
        logic        [PROD_W-1:0]  den;
        logic signed [SUM_W-1:0]   cross_prod;
        logic signed [DIFF_W-1:0]  wk;
        logic signed [COORD_W-1:0] rk;
        logic        [LEN_W-1:0]   len;
        logic        [SQ_W-1:0]    rad_sq;
        logic                      bad_sel;
    } front_out_t;

    typedef struct packed {
        logic [QUOT_W-1:0] quot;
        logic              ovf;
        logic              neg;
    } div_out_t;

endpackage

// ===== design/rapt_mul.sv =====
// Three-stage signed 66 by 66 bit multiplier built from partial products of 33 bit limbs.
module rapt_mul
    import rapt_pkg::*;
(
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [MUL_IN_W-1:0]  a,
    input  logic signed [MUL_IN_W-1:0]  b,
    output logic signed [MUL_OUT_W-1:0] p
);

    logic        [MUL_LIMB_W-1:0] a_lo;
    logic        [MUL_LIMB_W-1:0] b_lo;
    logic signed [MUL_LIMB_W-1:0] a_hi;
    logic signed [MUL_LIMB_W-1:0] b_hi;

    logic        [MUL_PP_W-1:0]   p00_reg;
    logic signed [MUL_X_W-1:0]    p01_reg;
    logic signed [MUL_X_W-1:0]    p10_reg;
    logic signed [MUL_PP_W-1:0]   p11_reg;
    logic signed [MUL_MID_W-1:0]  mid_reg;
    logic signed [MUL_OUT_W-1:0]  outer_reg;
    logic signed [MUL_OUT_W-1:0]  p_reg;

    assign a_lo = a[MUL_LIMB_W-1:0];
    assign b_lo = b[MUL_LIMB_W-1:0];
    assign a_hi = $signed(a[MUL_IN_W-1:MUL_LIMB_W]);
    assign b_hi = $signed(b[MUL_IN_W-1:MUL_LIMB_W]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg   <= MUL_PP_W'(a_lo) * MUL_PP_W'(b_lo);
            p01_reg   <= MUL_X_W'(a_hi) * $signed(MUL_X_W'(b_lo));
            p10_reg   <= $signed(MUL_X_W'(a_lo)) * MUL_X_W'(b_hi);
            p11_reg   <= MUL_PP_W'(a_hi) * MUL_PP_W'(b_hi);
            mid_reg   <= MUL_MID_W'(p01_reg) + MUL_MID_W'(p10_reg);
            outer_reg <= $signed({p11_reg, p00_reg});
            p_reg     <= outer_reg + (MUL_OUT_W'(mid_reg) <<< MUL_LIMB_W);
        end
    end

    assign p = p_reg;

endmodule

// ===== design/rapt_front.sv =====
// Front stages: axis selection, offsets, first products and the line sums.
module rapt_front
    import rapt_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [COORD_W-1:0] ray_origin_x,
    input  logic signed [COORD_W-1:0] ray_origin_y,
    input  logic signed [COORD_W-1:0] ray_origin_z,
    input  logic signed [COORD_W-1:0] ray_dir_x,
    input  logic signed [COORD_W-1:0] ray_dir_y,
    input  logic signed [COORD_W-1:0] ray_dir_z,
    input  logic signed [COORD_W-1:0] axis_origin_x,
    input  logic signed [COORD_W-1:0] axis_origin_y,
    input  logic signed [COORD_W-1:0] axis_origin_z,
    input  logic [1:0]                axis_select,
    input  logic [LEN_W-1:0]          segment_length,
    input  logic [LEN_W-1:0]          pick_radius,
    output front_out_t                fo
);

    logic signed [DIFF_W-1:0]  wx;
    logic signed [DIFF_W-1:0]  wy;
    logic signed [DIFF_W-1:0]  wz;
    logic signed [COORD_W-1:0] ri_next;
    logic signed [COORD_W-1:0] rj_next;
    logic signed [COORD_W-1:0] rk_next;
    logic signed [DIFF_W-1:0]  wi_next;
    logic signed [DIFF_W-1:0]  wj_next;
    logic signed [DIFF_W-1:0]  wk_next;
    logic                      bad_next;

    logic signed [COORD_W-1:0] ri_reg;
    logic signed [COORD_W-1:0] rj_reg;
    logic signed [COORD_W-1:0] rk1_reg;
    logic signed [DIFF_W-1:0]  wi_reg;
    logic signed [DIFF_W-1:0]  wj_reg;
    logic signed [DIFF_W-1:0]  wk1_reg;
    logic [LEN_W-1:0]          len1_reg;
    logic [LEN_W-1:0]          rad1_reg;
    logic                      bad1_reg;

    logic signed [PROD_W-1:0]  pii_reg;
    logic signed [PROD_W-1:0]  pjj_reg;
    logic signed [PROD_W-1:0]  piw_reg;
    logic signed [PROD_W-1:0]  pjw_reg;
    logic signed [PROD_W-1:0]  pij_reg;
    logic signed [PROD_W-1:0]  pji_reg;
    logic signed [COORD_W-1:0] rk2_reg;
    logic signed [DIFF_W-1:0]  wk2_reg;
    logic [LEN_W-1:0]          len2_reg;
    logic [SQ_W-1:0]           rad_sq_reg;
    logic                      bad2_reg;

    front_out_t                fo_reg;

    assign wx = DIFF_W'(ray_origin_x) - DIFF_W'(axis_origin_x);
    assign wy = DIFF_W'(ray_origin_y) - DIFF_W'(axis_origin_y);
    assign wz = DIFF_W'(ray_origin_z) - DIFF_W'(axis_origin_z);

    always_comb
    begin
        bad_next = 1'b0;
        unique case (axis_select)
            AXIS_X:
            begin
                ri_next = ray_dir_y;
                rj_next = ray_dir_z;
                rk_next = ray_dir_x;
                wi_next = wy;
                wj_next = wz;
                wk_next = wx;
            end
            AXIS_Y:
            begin
                ri_next = ray_dir_z;
                rj_next = ray_dir_x;
                rk_next = ray_dir_y;
                wi_next = wz;
                wj_next = wx;
                wk_next = wy;
            end
            AXIS_Z:
            begin
                ri_next = ray_dir_x;
                rj_next = ray_dir_y;
                rk_next = ray_dir_z;
                wi_next = wx;
                wj_next = wy;
                wk_next = wz;
            end
            default:
            begin
                ri_next  = ray_dir_y;
                rj_next  = ray_dir_z;
                rk_next  = ray_dir_x;
                wi_next  = wy;
                wj_next  = wz;
                wk_next  = wx;
                bad_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ri_reg   <= ri_next;
            rj_reg   <= rj_next;
            rk1_reg  <= rk_next;
            wi_reg   <= wi_next;
            wj_reg   <= wj_next;
            wk1_reg  <= wk_next;
            len1_reg <= segment_length;
            rad1_reg <= pick_radius;
            bad1_reg <= bad_next;

            pii_reg    <= PROD_W'(ri_reg) * PROD_W'(ri_reg);
            pjj_reg    <= PROD_W'(rj_reg) * PROD_W'(rj_reg);
            piw_reg    <= PROD_W'(ri_reg) * PROD_W'(wi_reg);
            pjw_reg    <= PROD_W'(rj_reg) * PROD_W'(wj_reg);
            pij_reg    <= PROD_W'(ri_reg) * PROD_W'(wj_reg);
            pji_reg    <= PROD_W'(rj_reg) * PROD_W'(wi_reg);
            rad_sq_reg <= SQ_W'(rad1_reg) * SQ_W'(rad1_reg);
            rk2_reg    <= rk1_reg;
            wk2_reg    <= wk1_reg;
            len2_reg   <= len1_reg;
            bad2_reg   <= bad1_reg;

            fo_reg.den        <= $unsigned(pii_reg) + $unsigned(pjj_reg);
            fo_reg.num        <= SUM_W'(piw_reg) + SUM_W'(pjw_reg);
            fo_reg.cross_prod <= SUM_W'(pij_reg) - SUM_W'(pji_reg);
            fo_reg.rk         <= rk2_reg;
            fo_reg.wk         <= wk2_reg;
            fo_reg.len        <= len2_reg;
            fo_reg.rad_sq     <= rad_sq_reg;
            fo_reg.bad_sel    <= bad2_reg;
        end
    end

    assign fo = fo_reg;

endmodule

// ===== design/rapt_div.sv =====
// Restoring divider pipeline for the ray parameter, one quotient bit per stage.
module rapt_div
    import rapt_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [SUM_W-1:0] num,
    input  logic [PROD_W-1:0]       den,
    output div_out_t                res
);

    logic [MAG_W-1:0]  mag;
    logic              neg_next;
    logic              ovf_next;

    logic [PROD_W-1:0] rem_reg [QUOT_W+1];
    logic [QUOT_W-1:0] xlo_reg [QUOT_W+1];
    logic [QUOT_W-1:0] quot_reg [QUOT_W+1];
    logic [PROD_W-1:0] den_reg [QUOT_W+1];
    logic              neg_reg [QUOT_W+1];
    logic              ovf_reg [QUOT_W+1];

    // The ray parameter is -num / den, so its sign is the opposite of num.
    assign mag      = num[SUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    assign neg_next = !num[SUM_W-1] && (num != '0);
    assign ovf_next = DIV_CMP_W'(mag) >= (DIV_CMP_W'(den) << DIV_SHIFT);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= PROD_W'(mag >> DIV_SHIFT);
            xlo_reg[0]  <= QUOT_W'(mag << FRAC_BITS);
            quot_reg[0] <= '0;
            den_reg[0]  <= den;
            neg_reg[0]  <= neg_next;
            ovf_reg[0]  <= ovf_next;
        end
    end

    for (genvar k = 1; k <= QUOT_W; k++)
    begin : g_step
        logic [PROD_W:0]   rem_sh;
        logic [PROD_W:0]   rem_sub;
        logic              take;

        always_comb
        begin
            rem_sh  = {rem_reg[k-1], xlo_reg[k-1][QUOT_W-1]};
            rem_sub = rem_sh - {1'b0, den_reg[k-1]};
            take    = rem_sh >= {1'b0, den_reg[k-1]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= take ? PROD_W'(rem_sub) : PROD_W'(rem_sh);
                xlo_reg[k]  <= xlo_reg[k-1] << 1;
                quot_reg[k] <= {quot_reg[k-1][QUOT_W-2:0], take};
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
            end
        end
    end

    assign res.quot = quot_reg[QUOT_W];
    assign res.ovf  = ovf_reg[QUOT_W];
    assign res.neg  = neg_reg[QUOT_W];

endmodule

// ===== design/ray_axis_pick_test.sv =====
// Top level of the ray to axis pick test pipeline.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    ray, axis, selector, length and radius
//   output    out_valid / out_ready  status, hit_distance
//
// One pick test can enter every cycle while the output is not stalled.
// The divider produces one quotient bit per stage.
// Reset clears only the valid bits; payload registers are left as they are.
// A stalled output freezes the whole pipeline, so no transfer is lost or repeated.
`include "ray_axis_pick_test_defines.svh"

module ray_axis_pick_test
    import rapt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] ray_origin_x,
    input  logic signed [COORD_W-1:0] ray_origin_y,
    input  logic signed [COORD_W-1:0] ray_origin_z,
    input  logic signed [COORD_W-1:0] ray_dir_x,
    input  logic signed [COORD_W-1:0] ray_dir_y,
    input  logic signed [COORD_W-1:0] ray_dir_z,
    input  logic signed [COORD_W-1:0] axis_origin_x,
    input  logic signed [COORD_W-1:0] axis_origin_y,
    input  logic signed [COORD_W-1:0] axis_origin_z,
    input  logic [1:0]                axis_select,
    input  logic [LEN_W-1:0]          segment_length,
    input  logic [LEN_W-1:0]          pick_radius,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                status,
    output logic signed [COORD_W-1:0] hit_distance
);

    logic                        en;
    logic [PIPE_DEPTH-1:0]       vld_reg;
    front_out_t                  fo;
    div_out_t                    dres;

    logic signed [MUL_OUT_W-1:0] p_wk_den;
    logic signed [MUL_OUT_W-1:0] p_rk_num;
    logic signed [MUL_OUT_W-1:0] p_len_den;
    logic signed [MUL_OUT_W-1:0] p_cross_sq;
    logic signed [MUL_OUT_W-1:0] p_rad_den;

    logic                        par_reg [MUL_LAT];
    logic signed [MUL_OUT_W-1:0] tt_reg;
    logic signed [MUL_OUT_W-1:0] lim_reg;
    logic                        far_reg;
    logic                        par6_reg;
    status_t                     stat_next;
    status_t                     stat_reg;
    status_t                     stat_dly_reg [STAT_DLY];
    status_t                     status_reg;
    logic [COORD_W-1:0]          dist_next;
    logic [COORD_W-1:0]          dist_reg;

    assign en        = !vld_reg[PIPE_DEPTH-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    rapt_front u_front (
        .clk            (clk),
        .en             (en),
        .ray_origin_x   (ray_origin_x),
        .ray_origin_y   (ray_origin_y),
        .ray_origin_z   (ray_origin_z),
        .ray_dir_x      (ray_dir_x),
        .ray_dir_y      (ray_dir_y),
        .ray_dir_z      (ray_dir_z),
        .axis_origin_x  (axis_origin_x),
        .axis_origin_y  (axis_origin_y),
        .axis_origin_z  (axis_origin_z),
        .axis_select    (axis_select),
        .segment_length (segment_length),
        .pick_radius    (pick_radius),
        .fo             (fo)
    );

    rapt_mul u_mul_wk_den (
        .clk (clk),
        .en  (en),
        .a   (MUL_IN_W'(fo.wk)),
        .b   ($signed(MUL_IN_W'(fo.den))),
        .p   (p_wk_den)
    );

    rapt_mul u_mul_rk_num (
        .clk (clk),
        .en  (en),
        .a   (MUL_IN_W'(fo.rk)),
        .b   (MUL_IN_W'(fo.num)),
        .p   (p_rk_num)
    );

    rapt_mul u_mul_len_den (
        .clk (clk),
        .en  (en),
        .a   ($signed(MUL_IN_W'(fo.len))),
        .b   ($signed(MUL_IN_W'(fo.den))),
        .p   (p_len_den)
    );

    rapt_mul u_mul_cross_sq (
        .clk (clk),
        .en  (en),
        .a   (MUL_IN_W'(fo.cross_prod)),
        .b   (MUL_IN_W'(fo.cross_prod)),
        .p   (p_cross_sq)
    );

    rapt_mul u_mul_rad_den (
        .clk (clk),
        .en  (en),
        .a   ($signed(MUL_IN_W'(fo.rad_sq))),
        .b   ($signed(MUL_IN_W'(fo.den))),
        .p   (p_rad_den)
    );

    rapt_div u_div (
        .clk (clk),
        .en  (en),
        .num (fo.num),
        .den (fo.den),
        .res (dres)
    );

    always_comb
    begin
        priority if (par6_reg)
        begin
            stat_next = STATUS_PARALLEL;
        end
        else if (tt_reg[MUL_OUT_W-1] || (tt_reg > lim_reg))
        begin
            stat_next = STATUS_OUTSIDE;
        end
        else if (far_reg)
        begin
            stat_next = STATUS_FAR;
        end
        else
        begin
            stat_next = STATUS_HIT;
        end
    end

    always_comb
    begin
        dist_next = '0;
        if (stat_dly_reg[STAT_DLY-1] == STATUS_HIT)
        begin
            if (!dres.neg)
            begin
                dist_next = (dres.ovf || dres.quot[QUOT_W-1]) ? SAT_MAX
                                                               : COORD_W'(dres.quot);
            end
            else
            begin
                dist_next = (dres.ovf || (dres.quot > SAT_MIN)) ? SAT_MIN
                                                                 : COORD_W'(-dres.quot);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            par_reg[0] <= fo.bad_sel || (fo.den < PARALLEL_EPS);
            for (int n = 1; n < MUL_LAT; n++)
            begin
                par_reg[n] <= par_reg[n-1];
            end
            tt_reg   <= p_wk_den - p_rk_num;
            lim_reg  <= p_len_den;
            far_reg  <= p_cross_sq > p_rad_den;
            par6_reg <= par_reg[MUL_LAT-1];
            stat_reg <= stat_next;
            stat_dly_reg[0] <= stat_reg;
            for (int n = 1; n < STAT_DLY; n++)
            begin
                stat_dly_reg[n] <= stat_dly_reg[n-1];
            end
            status_reg <= stat_dly_reg[STAT_DLY-1];
            dist_reg   <= dist_next;
        end
    end

    assign status       = status_reg;
    assign hit_distance = $signed(dist_reg);

    `RAPT_ASSERT_NOW(a_miss_has_zero_distance,
        out_valid && (status != STATUS_HIT), hit_distance == '0,
        "A result that is not a hit carries a nonzero distance.")

    `RAPT_ASSERT_NEXT(a_transfer_enters_pipe,
        in_valid && in_ready, vld_reg[0],
        "An accepted transfer did not enter the first stage.")

    `RAPT_ASSERT_NEXT(a_stall_holds_valids,
        !en, $stable(vld_reg),
        "The valid bits moved while the pipeline was stalled.")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the ray to axis pick test pipeline.
module tb;
    import rapt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [COORD_W-1:0] ro[3];
        logic signed [COORD_W-1:0] rd[3];
        logic signed [COORD_W-1:0] ao[3];
        logic [1:0]                sel;
        logic [LEN_W-1:0]          len;
        logic [LEN_W-1:0]          rad;
    } pick_t;

    typedef struct {
        status_t                   st;
        logic signed [COORD_W-1:0] distance;
    } pick_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [COORD_W-1:0] ray_origin_x, ray_origin_y, ray_origin_z;
    logic signed [COORD_W-1:0] ray_dir_x, ray_dir_y, ray_dir_z;
    logic signed [COORD_W-1:0] axis_origin_x, axis_origin_y, axis_origin_z;
    logic [1:0]                axis_select;
    logic [LEN_W-1:0]          segment_length;
    logic [LEN_W-1:0]          pick_radius;
    logic                      out_valid;
    logic                      out_ready;
    logic [1:0]                status;
    logic signed [COORD_W-1:0] hit_distance;

    pick_result_t expected_picks[$];
    logic         idling_on;
    int           mismatches;
    int           picks_sent;
    int           results_seen;
    int           status_count[4];
    int           quiet_cycles;

    ray_axis_pick_test dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .ray_origin_x(ray_origin_x), .ray_origin_y(ray_origin_y),
        .ray_origin_z(ray_origin_z),
        .ray_dir_x(ray_dir_x), .ray_dir_y(ray_dir_y), .ray_dir_z(ray_dir_z),
        .axis_origin_x(axis_origin_x), .axis_origin_y(axis_origin_y),
        .axis_origin_z(axis_origin_z),
        .axis_select(axis_select), .segment_length(segment_length),
        .pick_radius(pick_radius),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .hit_distance(hit_distance)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic pick_result_t predict_pick(pick_t p);
        pick_result_t             res;
        logic signed [COORD_W:0]  w[3];
        logic signed [191:0]      ri, rj, rk, wi, wj, wk;
        logic signed [191:0]      dn, nm, tt, lim, cr, c2, rr, ln, rdw;
        logic [191:0]             mag, q;
        logic [63:0]              den;
        int                       k, i, j;
        res.st = STATUS_PARALLEL;
        res.distance = '0;
        if (p.sel > 2'd2)
            return res;
        for (int c = 0; c < 3; c++)
            w[c] = {p.ro[c][COORD_W-1], p.ro[c]} - {p.ao[c][COORD_W-1], p.ao[c]};
        k = int'(p.sel);
        i = (k + 1) % 3;
        j = (k + 2) % 3;
        ri = 192'(p.rd[i]);
        rj = 192'(p.rd[j]);
        rk = 192'(p.rd[k]);
        wi = 192'(w[i]);
        wj = 192'(w[j]);
        wk = 192'(w[k]);
        dn = ri * ri + rj * rj;
        den = dn[63:0];
        if (den < PARALLEL_EPS)
            return res;
        nm = ri * wi + rj * wj;
        tt = wk * dn - rk * nm;
        ln = {161'd0, p.len};
        lim = ln * dn;
        if (tt < 0 || tt > lim)
        begin
            res.st = STATUS_OUTSIDE;
            return res;
        end
        cr = ri * wj - rj * wi;
        c2 = cr * cr;
        rdw = {161'd0, p.rad};
        rr = rdw * rdw * dn;
        if (c2 > rr)
        begin
            res.st = STATUS_FAR;
            return res;
        end
        nm = -nm;
        mag = (nm < 0) ? -nm : nm;
        q = (mag << FRAC_BITS) / {128'd0, den};
        res.st = STATUS_HIT;
        if (nm >= 0)
            res.distance = (q > 192'h7FFF_FFFF) ? SAT_MAX : q[31:0];
        else
            res.distance = (q > 192'h8000_0000) ? SAT_MIN : -q[31:0];
        return res;
    endfunction

    task automatic send_pick(pick_t p);
        while (idling_on && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        ray_origin_x   <= p.ro[0];
        ray_origin_y   <= p.ro[1];
        ray_origin_z   <= p.ro[2];
        ray_dir_x      <= p.rd[0];
        ray_dir_y      <= p.rd[1];
        ray_dir_z      <= p.rd[2];
        axis_origin_x  <= p.ao[0];
        axis_origin_y  <= p.ao[1];
        axis_origin_z  <= p.ao[2];
        axis_select    <= p.sel;
        segment_length <= p.len;
        pick_radius    <= p.rad;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_picks.push_back(predict_pick(p));
        picks_sent++;
    endtask

    function automatic pick_t make_pick(int ox, int oy, int oz, int dx, int dy, int dz,
                                        int ax, int ay, int az, logic [1:0] sel,
                                        int len, int rad);
        pick_t p;
        p.ro[0] = ox; p.ro[1] = oy; p.ro[2] = oz;
        p.rd[0] = dx; p.rd[1] = dy; p.rd[2] = dz;
        p.ao[0] = ax; p.ao[1] = ay; p.ao[2] = az;
        p.sel = sel;
        p.len = len[LEN_W-1:0];
        p.rad = rad[LEN_W-1:0];
        return p;
    endfunction

    // A ray aimed through a point of the axis, at most len/8 past the segment end, with a little jitter.
    function automatic pick_t aimed_pick();
        pick_t p;
        int    k, len, t, s;
        int    pt[3];
        k = $urandom_range(2);
        len = $urandom_range(1 << 22);
        t = $urandom_range(len + (len >> 3));
        s = $signed($urandom_range(16)) - 8;
        for (int c = 0; c < 3; c++)
        begin
            p.ao[c] = $signed($urandom_range(1 << 21)) - (1 << 20);
            p.rd[c] = $signed($urandom_range(1 << 19)) - (1 << 18);
            pt[c] = p.ao[c] + ((c == k) ? t : 0);
            p.ro[c] = pt[c] - s * p.rd[c] + $signed($urandom_range(1 << 13)) - (1 << 12);
        end
        p.sel = 2'(k);
        p.len = LEN_W'(len);
        p.rad = LEN_W'($urandom_range(1 << 15));
        return p;
    endfunction

    function automatic pick_t noise_pick();
        pick_t p;
        for (int c = 0; c < 3; c++)
        begin
            p.ro[c] = $urandom;
            p.rd[c] = $urandom;
            p.ao[c] = $urandom;
        end
        p.sel = 2'($urandom_range(3));
        p.len = LEN_W'($urandom);
        p.rad = LEN_W'($urandom);
        return p;
    endfunction

    function automatic pick_t near_parallel_pick();
        pick_t p;
        p = aimed_pick();
        for (int c = 0; c < 3; c++)
            if (c != p.sel)
                p.rd[c] = $signed($urandom_range(16)) - 8;
        p.rd[p.sel] = $urandom_range(1 << 16, 1 << 18);
        return p;
    endfunction

    function automatic pick_t random_pick();
        int m;
        m = $urandom_range(9);
        if (m < 6)
            return aimed_pick();
        else if (m < 8)
            return noise_pick();
        else
            return near_parallel_pick();
    endfunction

    task automatic test_directed();
        int one;
        one = 1 << FRAC_BITS;
        send_pick(make_pick(0, one, 0, 0, -one, 0, -one, 0, 0, AXIS_X, 2 * one, one / 4));
        send_pick(make_pick(0, 0, -one, 0, 0, one, 0, 0, 0, AXIS_Y, one, one));
        send_pick(make_pick(0, 0, 0, 0, 0, one, 0, 0, 0, AXIS_Z, one, one));
        send_pick(make_pick(0, one, 0, 0, -one, 0, 5 * one, 0, 0, AXIS_X, one, one));
        send_pick(make_pick(0, one, one, 0, -one, 0, 0, 0, 0, AXIS_X, one, one / 2));
        send_pick(make_pick(0, -one, 0, 0, -one, 0, 0, 0, 0, AXIS_X, one, one));
        send_pick(make_pick(0, one, 0, 0, -1, 0, 0, 0, 0, AXIS_X, one, one));
        send_pick(make_pick(0, 1 << 30, 0, 0, -1, 0, 0, 0, 0, AXIS_X, one, one));
        send_pick(make_pick(0, 1 << 30, 0, 0, 1, 0, 0, 0, 0, AXIS_X, one, one));
        send_pick(make_pick(0, one, 0, 0, -one, 0, 0, 0, 0, 2'd3, one, one));
        send_pick(make_pick(0, one, 0, 0, 7, 0, 0, 0, 0, AXIS_X, one, one));
        send_pick(make_pick(0, one, 0, 0, -one, 0, 0, 0, 0, AXIS_X, 0, 0));
        send_pick(make_pick(0, one, 0, 0, -one, 0, one, 0, 0, AXIS_X, 0, 0));
        send_pick(make_pick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            AXIS_Z, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_pick(make_pick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            AXIS_Y, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_pick(make_pick(32'h8000_0000, 0, 0, 32'h8000_0000, 32'h8000_0000, 0,
                            32'h7FFF_FFFF, 0, 0, AXIS_X, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_pick(make_pick(-1, -1, -1, -1, -1, -1, -1, -1, -1, 2'd3, -1, -1));
        send_pick(make_pick(0, 0, 0, 0, 0, 0, 0, 0, 0, AXIS_X, 0, 0));
    endtask

    task automatic test_random_picks(int count);
        idling_on = 1'b1;
        repeat (count)
            send_pick(random_pick());
    endtask

    task automatic test_back_to_back(int count);
        idling_on = 1'b0;
        repeat (count)
            send_pick(random_pick());
        idling_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !idling_on || ($urandom_range(99) >= 34);
    end

    always @(posedge clk)
    begin
        pick_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_picks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: status %0d distance %0d",
                             status, hit_distance);
            end
            else
            begin
                e = expected_picks.pop_front();
                status_count[e.st]++;
                if (status !== e.st || hit_distance !== e.distance)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected status %0d distance %0d, got %0d %0d",
                                 e.st, e.distance, status, hit_distance);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 3000)
        begin
            $display("Timed out with %0d results outstanding.", expected_picks.size());
            $display("[ray_axis_pick_test] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        idling_on = 1'b1;
        mismatches = 0;
        picks_sent = 0;
        results_seen = 0;
        quiet_cycles = 0;
        foreach (status_count[n])
            status_count[n] = 0;
        {ray_origin_x, ray_origin_y, ray_origin_z} = '0;
        {ray_dir_x, ray_dir_y, ray_dir_z} = '0;
        {axis_origin_x, axis_origin_y, axis_origin_z} = '0;
        axis_select = '0;
        segment_length = '0;
        pick_radius = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_picks(250);
        test_back_to_back(150);
        in_valid <= 1'b0;

        while (expected_picks.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);

        $display("Sent %0d pick tests and checked %0d results.", picks_sent, results_seen);
        $display("Hits %0d, parallel %0d, outside %0d, too far %0d, mismatches %0d.",
                 status_count[STATUS_HIT], status_count[STATUS_PARALLEL],
                 status_count[STATUS_OUTSIDE], status_count[STATUS_FAR], mismatches);
        if (mismatches == 0 && expected_picks.size() == 0)
            $display("[ray_axis_pick_test] OK");
        else
            $display("[ray_axis_pick_test] ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/rapt_pkg.sv
design/rapt_mul.sv
design/rapt_front.sv
design/rapt_div.sv
design/ray_axis_pick_test.sv
tb/sv/tb.sv
